[hdl/prf_pkg.sv]
// Shared constants, types and request structures for the page replacement block.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package prf_pkg;

  localparam int FRAME_COUNT = 4;
  localparam int PAGE_BITS   = 10;
  localparam int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
  localparam int FAULT_W     = 16;

  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  // Operand selection for the shared comparator.
  localparam logic CMP_SEL_PAGE = 1'b0;
  localparam logic CMP_SEL_IDX  = 1'b1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    page_t wr_page;
    logic  set_used;
  } ft_req_t;

  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    idx_t wr_data;
  } ol_req_t;

  typedef struct packed {
    logic  sel;
    page_t page_a;
    page_t page_b;
    idx_t  idx_a;
    idx_t  idx_b;
  } cmp_req_t;

endpackage

`default_nettype wire

[hdl/page_replacement_fifo_lru.sv]
// FIFO / LRU page replacement over FRAME_COUNT frames; top level with sequencer.
// One item is in work at a time, using the single shared comparator and the frame and
// order memories, each with one read and one write port; the next item is taken the
// cycle after the result enters the output register, never before the last is through.
// Synchronous active-high reset empties all frames, clears the fault count and selects
// least-recently-used mode.
`default_nettype none

module page_replacement_fifo_lru (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [9:0]  page_number,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        page_fault,
  output      logic [3:0]  frame_index,
  output      logic        evicted_valid,
  output      logic [9:0]  evicted_page,
  output      logic [15:0] fault_total
);
  import prf_pkg::*;

  // Sequencer states. The memories have registered reads, so every look-up
  // takes an issue state followed by a state that uses the data.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_FIND_RD  = 4'd3;
  localparam logic [3:0] S_FIND_CMP = 4'd4;
  localparam logic [3:0] S_VIC_RD   = 4'd5;
  localparam logic [3:0] S_VIC_PG   = 4'd6;
  localparam logic [3:0] S_VIC_WR   = 4'd7;
  localparam logic [3:0] S_SH_RD    = 4'd8;
  localparam logic [3:0] S_SH_WR    = 4'd9;
  localparam logic [3:0] S_TAIL_WR  = 4'd10;
  localparam logic [3:0] S_FILL     = 4'd11;
  localparam logic [3:0] S_RESP     = 4'd12;

  logic [3:0]         state, state_next;
  cnt_t               scan, scan_next;
  cnt_t               pos, pos_next;
  cnt_t               filled, filled_next;
  page_t              cur_page, cur_page_next;
  logic               cur_mode, cur_mode_next;
  idx_t               cur_frame, cur_frame_next;
  logic               hit, hit_next;
  logic               ev_valid, ev_valid_next;
  page_t              ev_page, ev_page_next;
  logic [FAULT_W-1:0] fault_cnt, fault_cnt_next;
  logic               policy;

  ft_req_t  ft_req;
  ol_req_t  ol_req;
  cmp_req_t cmp_req;
  page_t    ft_rd_page;
  logic     ft_rd_used;
  idx_t     ol_rd_data;
  logic     cmp_eq;
  logic     load_out;

  prf_frame_tbl u_frame_tbl (
    .clk     (clk),
    .rst     (rst),
    .req     (ft_req),
    .rd_page (ft_rd_page),
    .rd_used (ft_rd_used)
  );

  prf_order_list u_order_list (
    .clk     (clk),
    .req     (ol_req),
    .rd_data (ol_rd_data)
  );

  prf_match_unit u_match (
    .req (cmp_req),
    .eq  (cmp_eq)
  );

  // The output register is free when empty or when its item leaves now.
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_RESP) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    scan_next      = scan;
    pos_next       = pos;
    filled_next    = filled;
    cur_page_next  = cur_page;
    cur_mode_next  = cur_mode;
    cur_frame_next = cur_frame;
    hit_next       = hit;
    ev_valid_next  = ev_valid;
    ev_page_next   = ev_page;
    fault_cnt_next = fault_cnt;

    ft_req  = '0;
    ol_req  = '0;
    cmp_req = '0;

    cmp_req.page_a = ft_rd_page;
    cmp_req.page_b = cur_page;
    cmp_req.idx_a  = ol_rd_data;
    cmp_req.idx_b  = cur_frame;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur_page_next = PAGE_BITS'(page_number);
          cur_mode_next = policy;
          scan_next     = '0;
          hit_next      = 1'b0;
          ev_valid_next = 1'b0;
          ev_page_next  = '0;
          state_next    = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        ft_req.rd_en   = 1'b1;
        ft_req.rd_addr = scan[IDX_W-1:0];
        state_next     = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        cmp_req.sel = CMP_SEL_PAGE;
        if (ft_rd_used && cmp_eq) begin
          hit_next       = 1'b1;
          cur_frame_next = scan[IDX_W-1:0];
          pos_next       = '0;
          state_next     = cur_mode ? S_FIND_RD : S_RESP;
        end else if (scan == CNT_W'(FRAME_COUNT - 1)) begin
          state_next = (filled < CNT_W'(FRAME_COUNT)) ? S_FILL : S_VIC_RD;
        end else begin
          scan_next  = scan + CNT_W'(1);
          state_next = S_SCAN_RD;
        end
      end

      // Least-recently-used hit: locate the frame in the order list.
      S_FIND_RD: begin
        ol_req.rd_en   = 1'b1;
        ol_req.rd_addr = pos[IDX_W-1:0];
        state_next     = S_FIND_CMP;
      end

      S_FIND_CMP: begin
        cmp_req.sel = CMP_SEL_IDX;
        if (cmp_eq) begin
          state_next = S_SH_RD;
        end else if (pos + CNT_W'(1) >= filled) begin
          state_next = S_RESP;
        end else begin
          pos_next   = pos + CNT_W'(1);
          state_next = S_FIND_RD;
        end
      end

      // Replacement when full: the oldest frame is the victim.
      S_VIC_RD: begin
        ol_req.rd_en   = 1'b1;
        ol_req.rd_addr = '0;
        state_next     = S_VIC_PG;
      end

      S_VIC_PG: begin
        cur_frame_next = ol_rd_data;
        ft_req.rd_en   = 1'b1;
        ft_req.rd_addr = ol_rd_data;
        state_next     = S_VIC_WR;
      end

      S_VIC_WR: begin
        ev_valid_next  = 1'b1;
        ev_page_next   = ft_rd_page;
        ft_req.wr_en   = 1'b1;
        ft_req.wr_addr = cur_frame;
        ft_req.wr_page = cur_page;
        pos_next       = '0;
        state_next     = S_SH_RD;
      end

      // Move the entry at pos to the newest end, each shift taking a read state and a write state.
      S_SH_RD: begin
        if (pos + CNT_W'(1) < filled) begin
          ol_req.rd_en   = 1'b1;
          ol_req.rd_addr = IDX_W'(pos + CNT_W'(1));
          state_next     = S_SH_WR;
        end else begin
          state_next = S_TAIL_WR;
        end
      end

      S_SH_WR: begin
        ol_req.wr_en   = 1'b1;
        ol_req.wr_addr = pos[IDX_W-1:0];
        ol_req.wr_data = ol_rd_data;
        pos_next       = pos + CNT_W'(1);
        state_next     = S_SH_RD;
      end

      S_TAIL_WR: begin
        ol_req.wr_en   = 1'b1;
        ol_req.wr_addr = IDX_W'(filled - CNT_W'(1));
        ol_req.wr_data = cur_frame;
        state_next     = S_RESP;
      end

      // Miss with a free frame: frames fill in index order.
      S_FILL: begin
        cur_frame_next  = filled[IDX_W-1:0];
        ft_req.wr_en    = 1'b1;
        ft_req.wr_addr  = filled[IDX_W-1:0];
        ft_req.wr_page  = cur_page;
        ft_req.set_used = 1'b1;
        ol_req.wr_en    = 1'b1;
        ol_req.wr_addr  = filled[IDX_W-1:0];
        ol_req.wr_data  = filled[IDX_W-1:0];
        filled_next     = filled + CNT_W'(1);
        state_next      = S_RESP;
      end

      S_RESP: begin
        if (load_out) begin
          if (!hit && (fault_cnt != FAULT_MAX)) begin
            fault_cnt_next = fault_cnt + FAULT_W'(1);
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      filled    <= '0;
      fault_cnt <= '0;
      policy    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      filled    <= filled_next;
      fault_cnt <= fault_cnt_next;
      if (cfg_we) begin
        policy <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload need no reset.
  always_ff @(posedge clk) begin
    scan      <= scan_next;
    pos       <= pos_next;
    cur_page  <= cur_page_next;
    cur_mode  <= cur_mode_next;
    cur_frame <= cur_frame_next;
    hit       <= hit_next;
    ev_valid  <= ev_valid_next;
    ev_page   <= ev_page_next;
    if (load_out) begin
      page_fault    <= !hit;
      frame_index   <= 4'(cur_frame);
      evicted_valid <= ev_valid;
      evicted_page  <= 10'(ev_page);
      fault_total   <= fault_cnt_next;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while the previous one is still in work");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= CNT_W'(FRAME_COUNT))
    else $error("occupied frame count beyond the number of frames");

  a_fault_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (fault_cnt == $past(fault_cnt) || fault_cnt == $past(fault_cnt) + FAULT_W'(1)))
    else $error("fault count moved by more than one");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted_valid) |-> page_fault)
    else $error("eviction reported on a hit");

endmodule

`default_nettype wire

[hdl/prf_frame_tbl.sv]
// Frame table: page number per frame in a memory with one read and one write port, plus occupancy flags.
// Depends on prf_pkg.
`default_nettype none

module prf_frame_tbl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire prf_pkg::ft_req_t req,
  output      prf_pkg::page_t  rd_page,
  output      logic            rd_used
);
  import prf_pkg::*;

  page_t mem [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] used;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_page;
    end
    if (req.rd_en) begin
      rd_page <= mem[req.rd_addr];
      rd_used <= used[req.rd_addr];
    end
  end

  // Occupancy flags are cleared at once by reset; frames are never emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (req.wr_en && req.set_used) begin
      used[req.wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/prf_order_list.sv]
// Order list of frame indices, oldest first, held in a memory with one read and one write port.
// Depends on prf_pkg.
`default_nettype none

module prf_order_list (
  input  wire logic            clk,
  input  wire prf_pkg::ol_req_t req,
  output      prf_pkg::idx_t   rd_data
);
  import prf_pkg::*;

  idx_t mem [FRAME_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/prf_match_unit.sv]
// Shared equality comparator, used for page look-up and for order-list search.
// Depends on prf_pkg.
`default_nettype none

module prf_match_unit (
  input  wire prf_pkg::cmp_req_t req,
  output      logic             eq
);
  import prf_pkg::*;

  always_comb begin
    case (req.sel)
      CMP_SEL_PAGE: eq = (req.page_a == req.page_b);
      CMP_SEL_IDX:  eq = (req.idx_a == req.idx_b);
      default:      eq = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
